/* src/assert_macros.svh */
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every edge out of reset.
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BMHQ_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* src/bmhq_pkg.sv */
package bmhq_pkg;

  localparam int CAPACITY     = 1023;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int OP_BITS      = 2;
  localparam int STATUS_BITS  = 2;
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS    = CNT_BITS;
  localparam int DEPTH        = CAPACITY + 1;
  localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

  localparam logic [CNT_BITS-1:0]  CAP_CNT  = CNT_BITS'(CAPACITY);
  localparam logic [ADDR_BITS-1:0] ROOT_POS = ADDR_BITS'(1);

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PU_CMP,
    S_PO_LAST,
    S_DN_CMP,
    S_FIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_BITS-1:0]     count;
  } res_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_BITS-1:0]    waddr;
    logic [ENTRY_BITS-1:0]   wdata;
    logic [ADDR_BITS-1:0]    raddr_a;
    logic [ADDR_BITS-1:0]    raddr_b;
  } ram_req_t;

endpackage

/* src/bmhq_channels.sv */
interface bmhq_in_if;
  logic                              valid;
  logic                              ready;
  logic [bmhq_pkg::OP_BITS-1:0]      operation;
  logic [bmhq_pkg::KEY_BITS-1:0]     key;
  logic [bmhq_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

interface bmhq_out_if;
  logic                              valid;
  logic                              ready;
  logic [bmhq_pkg::STATUS_BITS-1:0]  status;
  logic [bmhq_pkg::KEY_BITS-1:0]     out_key;
  logic [bmhq_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic [bmhq_pkg::CNT_BITS-1:0]     count;

  modport source (output valid, output status, output out_key, output out_payload,
                  output count, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input count, output ready);
endinterface

/* src/bmhq_ram.sv */
module bmhq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/bmhq_seq.sv */
`include "assert_macros.svh"

module bmhq_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  bmhq_in_if.sink                             in_if,
  input  logic                                slot_free,
  output logic                                emit,
  output bmhq_pkg::res_t                      res,
  output bmhq_pkg::ram_req_t                  ram_req,
  input  logic [bmhq_pkg::ENTRY_BITS-1:0]     rd_a,
  input  logic [bmhq_pkg::ENTRY_BITS-1:0]     rd_b
);

  bmhq_pkg::state_t                   state_r, state_nxt;
  logic [bmhq_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [bmhq_pkg::ADDR_BITS-1:0]     pos_r, pos_nxt;
  bmhq_pkg::entry_t                   ent_r, ent_nxt;
  bmhq_pkg::entry_t                   root_r;
  bmhq_pkg::entry_t                   rep_r, rep_nxt;
  bmhq_pkg::status_t                  status_r, status_nxt;
  logic                               use_root_r, use_root_nxt;

  logic                               we;
  logic                               re;
  logic [bmhq_pkg::ADDR_BITS-1:0]     waddr, ra_a, ra_b;
  bmhq_pkg::entry_t                   wdata;

  bmhq_pkg::entry_t                   d_a, d_b, in_ent, child;
  logic [bmhq_pkg::CNT_BITS-1:0]      cnt_inc;
  logic [bmhq_pkg::ADDR_BITS-1:0]     parent;
  logic [bmhq_pkg::ADDR_BITS:0]       lpos, chpos;
  logic [bmhq_pkg::ADDR_BITS+1:0]     gpos;
  logic                               pick_right;
  logic                               in_acc;
  logic                               push_go;
  logic                               pop_go;
  logic                               rw_hit;

  assign d_a     = rd_a;
  assign d_b     = rd_b;
  assign in_ent  = '{key: in_if.key, payload: in_if.payload};
  assign cnt_inc = cnt_r + 1'b1;
  assign parent  = pos_r >> 1;
  assign lpos    = {pos_r, 1'b0};
  assign pick_right = (lpos != {1'b0, cnt_r}) && (d_a.key > d_b.key);
  assign child   = pick_right ? d_b : d_a;
  assign chpos   = lpos + {{bmhq_pkg::ADDR_BITS{1'b0}}, pick_right};
  assign gpos    = {chpos, 1'b0};
  assign in_if.ready = (state_r == bmhq_pkg::S_IDLE);
  assign in_acc  = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    ent_r      <= ent_nxt;
    rep_r      <= rep_nxt;
    status_r   <= status_nxt;
    use_root_r <= use_root_nxt;
    if (we && (waddr == bmhq_pkg::ROOT_POS)) begin
      root_r <= wdata;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    ent_nxt      = ent_r;
    rep_nxt      = rep_r;
    status_nxt   = status_r;
    use_root_nxt = use_root_r;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = ent_r;
    re           = 1'b0;
    ra_a         = '0;
    ra_b         = '0;
    emit         = 1'b0;
    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (in_if.valid) begin
          ent_nxt = in_ent;
          unique case (in_if.operation)
            bmhq_pkg::OP_PUSH: begin
              use_root_nxt = 1'b1;
              state_nxt    = bmhq_pkg::S_RESP;
              if (cnt_r == bmhq_pkg::CAP_CNT) begin
                status_nxt = bmhq_pkg::STAT_FULL;
              end else begin
                status_nxt = bmhq_pkg::STAT_DONE;
                cnt_nxt    = cnt_inc;
                pos_nxt    = cnt_inc;
                if (cnt_r == '0) begin
                  we    = 1'b1;
                  waddr = bmhq_pkg::ROOT_POS;
                  wdata = in_ent;
                end else begin
                  re        = 1'b1;
                  ra_a      = cnt_inc >> 1;
                  state_nxt = bmhq_pkg::S_PU_CMP;
                end
              end
            end
            bmhq_pkg::OP_POP: begin
              use_root_nxt = 1'b0;
              state_nxt    = bmhq_pkg::S_RESP;
              if (cnt_r == '0) begin
                status_nxt = bmhq_pkg::STAT_EMPTY;
                rep_nxt    = '0;
              end else begin
                status_nxt = bmhq_pkg::STAT_DONE;
                rep_nxt    = root_r;
                cnt_nxt    = cnt_r - 1'b1;
                if (cnt_r != bmhq_pkg::ROOT_POS) begin
                  re        = 1'b1;
                  ra_a      = cnt_r;
                  state_nxt = bmhq_pkg::S_PO_LAST;
                end
              end
            end
            default: begin
              state_nxt = bmhq_pkg::S_RESP;
              if (cnt_r == '0) begin
                status_nxt   = bmhq_pkg::STAT_EMPTY;
                rep_nxt      = '0;
                use_root_nxt = 1'b0;
              end else begin
                status_nxt   = bmhq_pkg::STAT_DONE;
                use_root_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      bmhq_pkg::S_PU_CMP: begin
        we = 1'b1;
        if (d_a.key > ent_r.key) begin
          wdata   = d_a;
          pos_nxt = parent;
          if (parent == bmhq_pkg::ROOT_POS) begin
            state_nxt = bmhq_pkg::S_FIN;
          end else begin
            re   = 1'b1;
            ra_a = parent >> 1;
          end
        end else begin
          state_nxt = bmhq_pkg::S_RESP;
        end
      end
      bmhq_pkg::S_PO_LAST: begin
        ent_nxt = d_a;
        pos_nxt = bmhq_pkg::ROOT_POS;
        if (cnt_r < bmhq_pkg::CNT_BITS'(2)) begin
          we        = 1'b1;
          waddr     = bmhq_pkg::ROOT_POS;
          wdata     = d_a;
          state_nxt = bmhq_pkg::S_RESP;
        end else begin
          re        = 1'b1;
          ra_a      = bmhq_pkg::ADDR_BITS'(2);
          ra_b      = bmhq_pkg::ADDR_BITS'(3);
          state_nxt = bmhq_pkg::S_DN_CMP;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        we = 1'b1;
        if (ent_r.key > child.key) begin
          wdata   = child;
          pos_nxt = chpos[bmhq_pkg::ADDR_BITS-1:0];
          if (gpos <= {2'b00, cnt_r}) begin
            re   = 1'b1;
            ra_a = gpos[bmhq_pkg::ADDR_BITS-1:0];
            ra_b = {gpos[bmhq_pkg::ADDR_BITS-1:1], 1'b1};
          end else begin
            state_nxt = bmhq_pkg::S_FIN;
          end
        end else begin
          state_nxt = bmhq_pkg::S_RESP;
        end
      end
      bmhq_pkg::S_FIN: begin
        we        = 1'b1;
        state_nxt = bmhq_pkg::S_RESP;
      end
      bmhq_pkg::S_RESP: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  assign ram_req = '{we: we, waddr: waddr, wdata: wdata, raddr_a: ra_a, raddr_b: ra_b};

  assign res.status  = status_r;
  assign res.key     = use_root_r ? root_r.key : rep_r.key;
  assign res.payload = use_root_r ? root_r.payload : rep_r.payload;
  assign res.count   = cnt_r;

  assign push_go = in_acc && (in_if.operation == bmhq_pkg::OP_PUSH)
                   && (cnt_r != bmhq_pkg::CAP_CNT);
  assign pop_go  = in_acc && (in_if.operation == bmhq_pkg::OP_POP) && (cnt_r != '0);
  assign rw_hit  = we && re && ((waddr == ra_a) || (waddr == ra_b));

  `BMHQ_ASSERT(a_cnt_cap, cnt_r <= bmhq_pkg::CAP_CNT, "entry count above capacity")
  `BMHQ_ASSERT(a_rw_clash, !rw_hit, "read/write clash")
  `BMHQ_ASSERT_NEXT(a_push_cnt, push_go, cnt_r == $past(cnt_r) + 1'b1, "push count step")
  `BMHQ_ASSERT_NEXT(a_pop_cnt, pop_go, cnt_r == $past(cnt_r) - 1'b1, "pop count step")

endmodule

/* src/binary_min_heap_queue.sv */
// Channel  Dir  Fields                                  Accept
// in_if    in   operation, key, payload                 valid && ready
// out_if   out  status, out_key, out_payload, count     valid && ready
//
// Peek, refused or empty requests, a push into an empty heap and a pop of the only entry are
// answered without a RAM pass; a push rises one level per pass, and a pop reads the last entry
// and then sinks it one level per pass. The next request is taken in the cycle after the emit.
// Each level costs one pass through the single heap RAM (one write and a registered read).
// Synchronous active-low reset empties the heap; the RAM needs no clearing pass.
// A finished result waits in the output register; a new request is taken while it stalls.
module binary_min_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  bmhq_in_if.sink     in_if,
  bmhq_out_if.source  out_if
);

  bmhq_pkg::ram_req_t                  ram_req;
  logic [bmhq_pkg::ENTRY_BITS-1:0]     rd_a, rd_b;
  bmhq_pkg::res_t                      res;
  bmhq_pkg::res_t                      out_res_r;
  logic                                out_valid_r;
  logic                                emit;
  logic                                slot_free;

  assign slot_free = !out_valid_r || out_if.ready;

  bmhq_ram #(
    .DEPTH (bmhq_pkg::DEPTH),
    .WIDTH (bmhq_pkg::ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  bmhq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res),
    .ram_req   (ram_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_res_r.status;
  assign out_if.out_key     = out_res_r.key;
  assign out_if.out_payload = out_res_r.payload;
  assign out_if.count       = out_res_r.count;

endmodule
